>>> src/swm_pkg.sv
// ----------------------------------------------------------------------------
// swm_pkg
// Types and constants shared by the sliding window maximum block.
// ----------------------------------------------------------------------------
package swm_pkg;

  localparam int SAMPLE_WIDTH    = 32;
  localparam int WS_WIDTH        = 7;
  localparam int CFG_DATA_WIDTH  = 32;
  localparam int CFG_ADDR_WIDTH  = 3;
  localparam int QUEUE_DEPTH     = 2;

  // register index taken from the word address
  localparam logic REG_WINDOW_SIZE = 1'b0;

  localparam logic [WS_WIDTH-1:0] WINDOW_SIZE_RESET = 7'd1;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic                           ends_stream;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] window_max;
    logic                           is_last_window;
  } out_item_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic                           last;
    logic [WS_WIDTH-1:0]            win;
  } cmd_t;

  typedef struct packed {
    logic valid;
    logic full;
  } queue_status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BACK,
    ST_FRONT,
    ST_PUSH
  } eng_state_t;

endpackage

>>> src/sliding_window_maximum.sv
// ----------------------------------------------------------------------------
// sliding_window_maximum
// Running maximum of a signed sample stream over the last window_size samples.
//
// Input channel in_valid/in_ready/in_data carries sample and ends_stream; the
// result channel out_valid/out_ready/out_data carries window_max and
// is_last_window. Each sample gives one result once window_size samples of
// the current stream have arrived, and none before. ends_stream clears the
// deque and the sample position after its own result.
// window_size sits at byte address 0 of the APB port (psel, penable, pwrite,
// paddr, pwdata, prdata, pready); pready is always high. Zero acts as one,
// values above WINDOW_MAX act as WINDOW_MAX.
// A two-entry queue decouples input from the deque engine. The engine fetches
// a sample, examines deque entries one at a time at the back and then at the
// front, and pushes the sample and posts the result; with an empty deque it
// goes straight from the fetch to the push. This order is set by the single
// read port of the deque memory. A stalled receiver holds the result register;
// input transfers continue until the queue fills. Reset empties the deque and
// sets window_size to one.
// ----------------------------------------------------------------------------
module sliding_window_maximum #(
  parameter int WINDOW_MAX = 64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  swm_pkg::in_item_t                    in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output swm_pkg::out_item_t                   out_data,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [swm_pkg::CFG_ADDR_WIDTH-1:0]   paddr,
  input  logic [swm_pkg::CFG_DATA_WIDTH-1:0]   pwdata,
  output logic [swm_pkg::CFG_DATA_WIDTH-1:0]   prdata,
  output logic                                 pready
);
  import swm_pkg::*;

  logic [WS_WIDTH-1:0] window_size_r;
  logic [WS_WIDTH-1:0] window_size_nxt;
  logic                cfg_wr;
  logic                reg_sel;
  queue_status_t       q_status;
  logic                q_push;
  logic                q_pop;
  cmd_t                push_cmd;
  cmd_t                pop_cmd;

  assign reg_sel = (paddr[CFG_ADDR_WIDTH-1] == REG_WINDOW_SIZE);
  assign cfg_wr  = psel && penable && pwrite && reg_sel;
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? {{(CFG_DATA_WIDTH-WS_WIDTH){1'b0}}, window_size_r} : '0;

  always_comb begin
    window_size_nxt = cfg_wr ? pwdata[WS_WIDTH-1:0] : window_size_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_size_r <= WINDOW_SIZE_RESET;
    end else begin
      window_size_r <= window_size_nxt;
    end
  end

  swm_front #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_front (
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .window_size (window_size_r),
    .q_status    (q_status),
    .q_push      (q_push),
    .q_cmd       (push_cmd)
  );

  swm_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .pop_cmd  (pop_cmd),
    .status   (q_status)
  );

  swm_engine #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_status  (q_status),
    .q_cmd     (pop_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |=> q_status.valid)
    else $error("transfer did not reach the queue");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_status.valid)
    else $error("engine popped an empty queue");

  a_win_range: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (push_cmd.win != '0) && (32'(push_cmd.win) <= 32'(WINDOW_MAX)))
    else $error("clamped window size out of range");

  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> q_status.full)
    else $error("input stalled with room in the queue");

endmodule

>>> src/swm_front.sv
// ----------------------------------------------------------------------------
// swm_front
// Input side: takes samples while the queue has room and clamps the window
// size into a command for the deque engine.
// ----------------------------------------------------------------------------
module swm_front #(
  parameter int WINDOW_MAX = 64
) (
  input  logic                             in_valid,
  output logic                             in_ready,
  input  swm_pkg::in_item_t                in_data,
  input  logic [swm_pkg::WS_WIDTH-1:0]     window_size,
  input  swm_pkg::queue_status_t           q_status,
  output logic                             q_push,
  output swm_pkg::cmd_t                    q_cmd
);
  import swm_pkg::*;

  logic [31:0] ws_wide;
  logic [31:0] win_wide;

  always_comb begin
    ws_wide = {{(32-WS_WIDTH){1'b0}}, window_size};
    if (ws_wide == 32'd0) begin
      win_wide = 32'd1;
    end else if (ws_wide > 32'(WINDOW_MAX)) begin
      win_wide = 32'(WINDOW_MAX);
    end else begin
      win_wide = ws_wide;
    end
  end

  assign in_ready    = !q_status.full;
  assign q_push      = in_valid && !q_status.full;
  assign q_cmd.sample = in_data.sample;
  assign q_cmd.last   = in_data.ends_stream;
  assign q_cmd.win    = win_wide[WS_WIDTH-1:0];

endmodule

>>> src/swm_fifo.sv
// ----------------------------------------------------------------------------
// swm_fifo
// Two-entry command queue between the input side and the deque engine.
// ----------------------------------------------------------------------------
module swm_fifo (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  swm_pkg::cmd_t          push_cmd,
  input  logic                   pop,
  output swm_pkg::cmd_t          pop_cmd,
  output swm_pkg::queue_status_t status
);
  import swm_pkg::*;

  cmd_t       slot_r [QUEUE_DEPTH];
  logic       wr_ptr_r;
  logic       wr_ptr_nxt;
  logic       rd_ptr_r;
  logic       rd_ptr_nxt;
  logic [1:0] count_r;
  logic [1:0] count_nxt;
  logic       do_push;
  logic       do_pop;

  always_comb begin
    do_push    = push && (count_r != 2'(QUEUE_DEPTH));
    do_pop     = pop && (count_r != 2'd0);
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  assign pop_cmd      = slot_r[rd_ptr_r];
  assign status.valid = (count_r != 2'd0);
  assign status.full  = (count_r == 2'(QUEUE_DEPTH));

endmodule

>>> src/swm_engine.sv
// ----------------------------------------------------------------------------
// swm_engine
// Deque engine: pops the back and the front of the monotonic deque one entry
// per cycle, pushes the sample and registers the window maximum.
// ----------------------------------------------------------------------------
module swm_engine #(
  parameter int WINDOW_MAX = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  swm_pkg::queue_status_t q_status,
  input  swm_pkg::cmd_t          q_cmd,
  output logic                   q_pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output swm_pkg::out_item_t     out_data
);
  import swm_pkg::*;

  localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int PW = $clog2(WINDOW_MAX) + 1;
  localparam int CW = $clog2(WINDOW_MAX + 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(WINDOW_MAX - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(WINDOW_MAX);

  logic signed [SAMPLE_WIDTH-1:0] val_mem [WINDOW_MAX];
  logic [PW-1:0]                  pos_mem [WINDOW_MAX];

  eng_state_t state_r;
  eng_state_t state_nxt;
  cmd_t       cmd_r;
  cmd_t       cmd_nxt;
  logic [AW-1:0] head_r;
  logic [AW-1:0] head_nxt;
  logic [AW-1:0] tail_r;
  logic [AW-1:0] tail_nxt;
  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  logic [PW-1:0] pos_r;
  logic [PW-1:0] pos_nxt;
  logic          filled_r;
  logic          filled_nxt;
  logic          out_valid_r;
  logic          out_valid_nxt;
  out_item_t     out_data_r;
  out_item_t     out_data_nxt;
  logic signed [SAMPLE_WIDTH-1:0] rd_val_r;
  logic [PW-1:0]                  rd_pos_r;

  logic [AW-1:0] back_addr;
  logic [AW-1:0] back2_addr;
  logic [AW-1:0] head_inc;
  logic [AW-1:0] tail_inc;
  logic [AW-1:0] rd_addr;
  logic          rd_en;
  logic          wr_en;
  logic [PW-1:0] age;
  logic          back_pop;
  logic          front_pop;
  logic          has_result;
  logic          out_free;
  logic          commit;
  logic          single;

  always_comb begin
    back_addr  = (tail_r == '0) ? LAST_ADDR : tail_r - AW'(1);
    back2_addr = (back_addr == '0) ? LAST_ADDR : back_addr - AW'(1);
    head_inc   = (head_r == LAST_ADDR) ? '0 : head_r + AW'(1);
    tail_inc   = (tail_r == LAST_ADDR) ? '0 : tail_r + AW'(1);
    age        = pos_r - rd_pos_r;
    back_pop   = (rd_val_r <= cmd_r.sample);
    front_pop  = (32'(age) >= 32'(cmd_r.win));
    has_result = filled_r || ((32'(pos_r) + 32'd1) >= 32'(cmd_r.win));
    out_free   = !out_valid_r || out_ready;
    single     = (count_r == CW'(1));
    commit     = (state_r == ST_PUSH) && (!has_result || out_free);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (q_status.valid) begin
          state_nxt = (count_r == '0) ? ST_PUSH : ST_BACK;
        end
      end
      ST_BACK: begin
        if (back_pop) begin
          state_nxt = single ? ST_PUSH : ST_BACK;
        end else begin
          state_nxt = ST_FRONT;
        end
      end
      ST_FRONT: begin
        state_nxt = (front_pop && !single) ? ST_FRONT : ST_PUSH;
      end
      ST_PUSH: begin
        if (commit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop         = 1'b0;
    cmd_nxt       = cmd_r;
    rd_en         = 1'b0;
    rd_addr       = head_r;
    wr_en         = 1'b0;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    pos_nxt       = pos_r;
    filled_nxt    = filled_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    case (state_r)
      ST_IDLE: begin
        if (q_status.valid) begin
          q_pop   = 1'b1;
          cmd_nxt = q_cmd;
          if (count_r != '0) begin
            rd_en   = 1'b1;
            rd_addr = back_addr;
          end
        end
      end
      ST_BACK: begin
        if (back_pop) begin
          tail_nxt  = back_addr;
          count_nxt = count_r - CW'(1);
          if (!single) begin
            rd_en   = 1'b1;
            rd_addr = back2_addr;
          end
        end else begin
          rd_en   = 1'b1;
          rd_addr = head_r;
        end
      end
      ST_FRONT: begin
        if (front_pop) begin
          head_nxt  = head_inc;
          count_nxt = count_r - CW'(1);
          if (!single) begin
            rd_en   = 1'b1;
            rd_addr = head_inc;
          end
        end
      end
      ST_PUSH: begin
        if (commit) begin
          if (count_r != FULL_COUNT) begin
            wr_en     = 1'b1;
            tail_nxt  = tail_inc;
            count_nxt = count_r + CW'(1);
          end
          if (has_result) begin
            out_valid_nxt             = 1'b1;
            out_data_nxt.window_max     = (count_r == '0) ? cmd_r.sample : rd_val_r;
            out_data_nxt.is_last_window = cmd_r.last;
          end
          if (cmd_r.last) begin
            head_nxt   = '0;
            tail_nxt   = '0;
            count_nxt  = '0;
            pos_nxt    = '0;
            filled_nxt = 1'b0;
          end else begin
            pos_nxt    = pos_r + PW'(1);
            filled_nxt = has_result;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      pos_r       <= '0;
      filled_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      pos_r       <= pos_nxt;
      filled_r    <= filled_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      val_mem[tail_r] <= cmd_r.sample;
      pos_mem[tail_r] <= pos_r;
    end
    if (rd_en) begin
      rd_val_r <= val_mem[rd_addr];
      rd_pos_r <= pos_mem[rd_addr];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> verif/sliding_window_maximum_checker.sv
// ----------------------------------------------------------------------------
// sliding_window_maximum_checker
// Watches the sample, result and register ports of the sliding window
// maximum block. It keeps its own monotonic deque of held samples, queues the
// window maximum that each sample transfer should yield, and compares every
// result transfer field by field against the oldest queued maximum. It also
// checks that reads of window_size return the value last written.
// ----------------------------------------------------------------------------
module sliding_window_maximum_checker #(
  parameter int WINDOW_MAX = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  swm_pkg::in_item_t                  in_data,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  swm_pkg::out_item_t                 out_data,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [swm_pkg::CFG_ADDR_WIDTH-1:0] paddr,
  input  logic [swm_pkg::CFG_DATA_WIDTH-1:0] pwdata,
  input  logic [swm_pkg::CFG_DATA_WIDTH-1:0] prdata,
  input  logic                               pready,
  output int                                 mismatch_count,
  output int                                 maxima_checked,
  output int                                 maxima_pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import swm_pkg::*;

  localparam logic [CFG_ADDR_WIDTH-1:0] WS_ADDR = {REG_WINDOW_SIZE, 2'b00};

  logic signed [SAMPLE_WIDTH-1:0] held_value [WINDOW_MAX];
  logic [31:0]                    held_position [WINDOW_MAX];
  int unsigned                    front_slot;
  int unsigned                    back_slot;
  int unsigned                    held_count;
  logic [31:0]                    stream_position;
  bit                             window_filled;
  logic [WS_WIDTH-1:0]            window_size;
  out_item_t                      expected_maxima [$];
  out_item_t                      oldest;

  task automatic report_mismatch(input string what);
    $display("%0t: %s", $time, what);
    mismatch_count++;
  endtask

  task automatic clear_stream();
    front_slot = 0;
    back_slot = 0;
    held_count = 0;
    stream_position = '0;
    window_filled = 1'b0;
  endtask

  task automatic advance_window(input in_item_t item);
    logic signed [SAMPLE_WIDTH-1:0] value;
    logic [31:0]                    span;
    logic [31:0]                    age;
    int unsigned                    slot;
    out_item_t                      window_result;
    value = item.sample;
    span = (window_size == 0) ? 32'd1 :
           (window_size > WINDOW_MAX) ? 32'(WINDOW_MAX) : 32'(window_size);
    // drop held samples at or below the new one
    while (held_count > 0) begin
      slot = (back_slot + WINDOW_MAX - 1) % WINDOW_MAX;
      if (held_value[slot] > value) break;
      back_slot = slot;
      held_count--;
    end
    // drop samples that have left the window
    while (held_count > 0) begin
      age = stream_position - held_position[front_slot];
      if (age < span) break;
      front_slot = (front_slot + 1) % WINDOW_MAX;
      held_count--;
    end
    if (held_count < WINDOW_MAX) begin
      held_value[back_slot] = value;
      held_position[back_slot] = stream_position;
      back_slot = (back_slot + 1) % WINDOW_MAX;
      held_count++;
    end
    if (stream_position >= span - 1) window_filled = 1'b1;
    if (window_filled) begin
      window_result.window_max = held_value[front_slot];
      window_result.is_last_window = item.ends_stream;
      expected_maxima = {expected_maxima, window_result};
    end
    stream_position++;
    if (item.ends_stream) clear_stream();
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      window_size = WINDOW_SIZE_RESET;
      clear_stream();
      expected_maxima.delete();
    end else begin
      if (psel && penable && pready && paddr == WS_ADDR) begin
        if (pwrite) begin
          window_size = pwdata[WS_WIDTH-1:0];
        end else if (prdata[WS_WIDTH-1:0] !== window_size) begin
          report_mismatch($sformatf("window_size read back %0d, expected %0d",
                                    prdata[WS_WIDTH-1:0], window_size));
        end
      end
      if (out_valid && out_ready) begin
        if (expected_maxima.size() == 0) begin
          report_mismatch($sformatf("result transfer max=%0d last=%0b with none due",
                                    out_data.window_max, out_data.is_last_window));
        end else begin
          oldest = expected_maxima[0];
          expected_maxima.delete(0);
          maxima_checked++;
          if (out_data.window_max !== oldest.window_max)
            report_mismatch($sformatf("window_max %0d, expected %0d",
                                      out_data.window_max, oldest.window_max));
          if (out_data.is_last_window !== oldest.is_last_window)
            report_mismatch($sformatf("is_last_window %0b, expected %0b",
                                      out_data.is_last_window, oldest.is_last_window));
        end
      end
      if (in_valid && in_ready) advance_window(in_data);
    end
    maxima_pending <= expected_maxima.size();
  end

endmodule

>>> verif/sliding_window_maximum_tb.sv
// ----------------------------------------------------------------------------
// sliding_window_maximum_tb
// Drives the sliding window maximum block with directed and random sample
// streams under a series of window sizes, including zero, saturating sizes
// and changes in the middle of a stream. Sender gaps and receiver stalls vary
// by phase, and one long receiver hold-off backs the block up. A separate
// checker predicts and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module sliding_window_maximum_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import swm_pkg::*;

  localparam int DEQUE_DEPTH   = 64;
  localparam int SETTLE_CYCLES = 300;
  localparam int HOLD_CYCLES   = 300;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int PHASES        = 16;
  localparam logic [CFG_ADDR_WIDTH-1:0] WS_ADDR = {REG_WINDOW_SIZE, 2'b00};

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  in_item_t                  in_data = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  out_item_t                 out_data;
  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic [CFG_ADDR_WIDTH-1:0] paddr = '0;
  logic [CFG_DATA_WIDTH-1:0] pwdata = '0;
  logic [CFG_DATA_WIDTH-1:0] prdata;
  logic                      pready;

  int mismatch_count;
  int maxima_checked;
  int maxima_pending;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;
  int samples_sent = 0;
  int streams_ended = 0;
  int sizes_written = 0;
  int cycle_count;

  always #1 clk = ~clk;

  sliding_window_maximum #(
    .WINDOW_MAX(DEQUE_DEPTH)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  sliding_window_maximum_checker #(
    .WINDOW_MAX(DEQUE_DEPTH)
  ) u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .mismatch_count(mismatch_count),
    .maxima_checked(maxima_checked),
    .maxima_pending(maxima_pending)
  );

  task automatic send_sample(input logic signed [SAMPLE_WIDTH-1:0] value, input logic last);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{sample: value, ends_stream: last};
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    samples_sent++;
    if (last) streams_ended++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk); while (maxima_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_window(input logic [WS_WIDTH-1:0] size);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= WS_ADDR;
    pwdata <= ($urandom_range(1) == 1) ? (($urandom << WS_WIDTH) | 32'(size)) : 32'(size);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    // read it back
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    sizes_written++;
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk);
    $display("sliding_window_maximum: mismatch");
    $finish;
  end

  initial begin
    logic [WS_WIDTH-1:0]            size_plan [12];
    logic [WS_WIDTH-1:0]            size;
    int unsigned                    span;
    int unsigned                    stream_left;
    int unsigned                    pattern;
    int                             phase;
    int                             count;
    logic signed [SAMPLE_WIDTH-1:0] value;

    size_plan = '{7'd64, 7'd0, 7'd127, 7'd2, 7'd3, 7'd5, 7'd1, 7'd8,
                  7'd40, 7'd16, 7'd65, 7'd4};
    stream_left = 0;
    pattern = 0;
    value = '0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // extremes under the reset window of one
    send_sample(32'sh7FFF_FFFF, 1'b0);
    send_sample(32'sh8000_0000, 1'b0);
    send_sample(32'sh0000_0000, 1'b0);
    send_sample(-32'sd1, 1'b1);
    settle();

    // zero acts as one
    write_window(7'd0);
    send_sample(32'sd5, 1'b0);
    send_sample(-32'sd5, 1'b1);
    settle();

    // short stream, then ties
    write_window(7'd4);
    send_sample(32'sd1, 1'b0);
    send_sample(32'sd2, 1'b0);
    send_sample(32'sd3, 1'b1);
    repeat (4) send_sample(32'sd7, 1'b0);
    send_sample(32'sd3, 1'b0);
    send_sample(32'sd7, 1'b1);
    settle();

    // saturated size, then a smaller one mid-stream
    write_window(7'd127);
    send_sample(-32'sd9, 1'b0);
    send_sample(32'sd12, 1'b0);
    settle();
    write_window(7'd2);
    send_sample(32'sd4, 1'b0);
    send_sample(-32'sd20, 1'b0);
    send_sample(-32'sd30, 1'b1);
    settle();

    for (phase = 0; phase < PHASES; phase++) begin
      size = (phase < 12) ? size_plan[phase] : WS_WIDTH'($urandom_range(2, 10));
      span = (size == 0) ? 1 : (size > DEQUE_DEPTH) ? DEQUE_DEPTH : size;
      case (phase % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          send_idle_pct = 79;
          stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 79;
        end
        default: begin
          send_idle_pct = 30;
          stall_pct = 30;
        end
      endcase
      write_window(size);
      if (phase == 4) hold_left = HOLD_CYCLES;
      count = (span >= 32) ? 60 : 16;
      repeat (count) begin
        if (stream_left == 0) begin
          stream_left = ($urandom_range(3) == 0) ? $urandom_range(1, span)
                                                 : $urandom_range(span, 3 * span + 4);
          pattern = $urandom_range(3);
          value = $urandom;
        end
        case (pattern)
          0: begin
            case ($urandom_range(7))
              0: value = 32'sh7FFF_FFFF;
              1: value = 32'sh8000_0000;
              default: value = $urandom;
            endcase
          end
          1: value = value - $urandom_range(1, 1000);
          2: value = value + $urandom_range(0, 1000);
          default: value = int'($urandom_range(6)) - 3;
        endcase
        stream_left--;
        send_sample(value, stream_left == 0);
      end
      settle();
    end

    $display("Ran %0d samples in %0d ended streams over %0d window size writes,",
             samples_sent, streams_ended, sizes_written);
    $display("with %0d window maxima compared under mixed gaps, stalls and one long hold-off.",
             maxima_checked);
    if (mismatch_count == 0) begin
      $display("sliding_window_maximum: match");
    end else begin
      $display("sliding_window_maximum: mismatch");
    end
    $finish;
  end

endmodule

>>> sliding_window_maximum.f
src/swm_pkg.sv
src/swm_front.sv
src/swm_fifo.sv
src/swm_engine.sv
src/sliding_window_maximum.sv
verif/sliding_window_maximum_checker.sv
verif/sliding_window_maximum_tb.sv
